>>> hw/rtl/psc_pkg.sv
// shared constants and types for the pressure sensor compensation block
package psc_pkg;

  localparam int CalWidth = 16;
  localparam int CalCount = 6;
  localparam int CalIndexWidth = 3;
  localparam int SampleWidth = 24;
  localparam int TempWidth = 19;
  localparam int PressWidth = 28;
  localparam int DepthWidth = 33;
  localparam int OperandWidth = 40;
  localparam int ProductWidth = 80;

  localparam logic [1:0] ACT_TEMP = 2'd0;
  localparam logic [1:0] ACT_PRESS = 2'd1;
  localparam logic [1:0] ACT_REARM = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [CalIndexWidth-1:0] REG_C1 = 3'd0;
  localparam logic [CalIndexWidth-1:0] REG_C2 = 3'd1;
  localparam logic [CalIndexWidth-1:0] REG_C3 = 3'd2;
  localparam logic [CalIndexWidth-1:0] REG_C4 = 3'd3;
  localparam logic [CalIndexWidth-1:0] REG_C5 = 3'd4;
  localparam logic [CalIndexWidth-1:0] REG_C6 = 3'd5;

  localparam logic signed [OperandWidth-1:0] DepthMul = 40'sd666277;

  typedef struct packed {
    logic start;
    logic signed [OperandWidth-1:0] a;
    logic signed [OperandWidth-1:0] b;
  } mul_req_t;

  // truncating signed division by 2^k
  function automatic logic signed [ProductWidth-1:0] div_pow2(
    input logic signed [ProductWidth-1:0] v, input int unsigned k);
    logic signed [ProductWidth-1:0] bias;
    bias = v[ProductWidth-1] ? ((ProductWidth'(1) << k) - ProductWidth'(1)) : '0;
    return (v + bias) >>> k;
  endfunction

  function automatic logic signed [ProductWidth-1:0] sat(
    input logic signed [ProductWidth-1:0] v, input int unsigned w);
    logic signed [ProductWidth-1:0] hi;
    logic signed [ProductWidth-1:0] lo;
    hi = (ProductWidth'(1) <<< (w - 1)) - ProductWidth'(1);
    lo = -(ProductWidth'(1) <<< (w - 1));
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

endpackage

>>> hw/rtl/pressure_sensor_compensation.sv
// pressure sensor compensation top level: sequencer, calibration and state
// temperature: S_T1, S_T6, S_T2, S_T3, S_T4, S_T5, S_OUT; pressure: S_P1, S_P2, S_P3, S_OUT
// each multiply goes through psc_mul: issue, four digit steps, done; re-arm goes straight to S_OUT
// s_tready high only when idle; a finished result waits in the output register
// a new item is taken only after the previous result has moved into the output register
// rst clears calibration, offset, sensitivity, baseline and arms the baseline
module pressure_sensor_compensation (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [23:0] s_tdata,   // adc_sample
  input  logic [1:0] s_tuser,    // action
  output logic m_tvalid,
  input  logic m_tready,
  output logic [79:0] m_tdata,   // temperature_centi_c, pressure_tenth_mbar, depth_hundredth_cm
  output logic [1:0] m_tuser,    // result_kind
  input  logic cfg_we,
  input  logic [psc_pkg::CalIndexWidth-1:0] cfg_index,
  input  logic [psc_pkg::CalWidth-1:0] cfg_data
);
  import psc_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_T1 = 4'd1;
  localparam logic [3:0] S_T2 = 4'd2;
  localparam logic [3:0] S_T3 = 4'd3;
  localparam logic [3:0] S_T4 = 4'd4;
  localparam logic [3:0] S_T5 = 4'd5;
  localparam logic [3:0] S_P1 = 4'd6;
  localparam logic [3:0] S_P2 = 4'd7;
  localparam logic [3:0] S_OUT = 4'd8;
  localparam logic [3:0] S_T6 = 4'd9;
  localparam logic [3:0] S_P3 = 4'd10;

  logic [3:0] state;
  logic [CalWidth-1:0] c1, c2, c3, c4, c5, c6;
  logic signed [63:0] off_val, sens_val;
  logic signed [PressWidth-1:0] base_p;
  logic armed;
  logic [1:0] action;
  logic [SampleWidth-1:0] sample;
  logic signed [OperandWidth-1:0] dt;
  logic signed [ProductWidth-1:0] temp, offw, sensw, pw;
  logic signed [ProductWidth-1:0] r_temp, r_press, r_depth;
  logic waiting;
  mul_req_t req;
  logic mdone;
  logic signed [ProductWidth-1:0] prod;
  logic signed [ProductWidth-1:0] aux, psat;
  logic signed [OperandWidth-1:0] pdiff;
  logic signed [OperandWidth-1:0] tdiff;
  logic [1:0] out_kind;
  logic [79:0] out_data;

  psc_mul u_mul (.clk(clk), .rst(rst), .req(req), .done(mdone), .product(prod));

  assign s_tready = (state == S_IDLE);
  assign tdiff = OperandWidth'(temp - 80'sd2000);
  assign psat = sat(pw, PressWidth);

  always_comb begin
    req = '0;
    case (state)
      S_T1: req.a = dt;
      S_T2: req.a = dt;
      S_T3: req.a = dt;
      S_T4: req.a = dt;
      S_T6: req.a = tdiff;
      S_P1: req.a = OperandWidth'(sample);
      S_P3: req.a = pdiff;
      default: req.a = '0;
    endcase
    case (state)
      S_T1: req.b = OperandWidth'(c6);
      S_T2: req.b = OperandWidth'(c4);
      S_T3: req.b = OperandWidth'(c3);
      S_T4: req.b = dt;
      S_T6: req.b = tdiff;
      S_P1: req.b = sens_val[OperandWidth-1:0];
      S_P3: req.b = DepthMul;
      default: req.b = '0;
    endcase
    req.start = !waiting && (state == S_T1 || state == S_T2 || state == S_T3 ||
                             state == S_T4 || state == S_T6 || state == S_P1 ||
                             state == S_P3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0; c2 <= '0; c3 <= '0; c4 <= '0; c5 <= '0; c6 <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_C1: c1 <= cfg_data;
        REG_C2: c2 <= cfg_data;
        REG_C3: c3 <= cfg_data;
        REG_C4: c4 <= cfg_data;
        REG_C5: c5 <= cfg_data;
        REG_C6: c6 <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      waiting <= 1'b0;
      m_tvalid <= 1'b0;
      off_val <= '0;
      sens_val <= '0;
      base_p <= '0;
      armed <= 1'b1;
    end else begin
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
        out_kind <= action;
        out_data <= {r_depth[DepthWidth-1:0], r_press[PressWidth-1:0],
                     r_temp[TempWidth-1:0]};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (req.start) waiting <= 1'b1;
      if (mdone) waiting <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            action <= s_tuser;
            sample <= s_tdata;
            dt <= OperandWidth'(s_tdata) - (OperandWidth'(c5) << 8);
            r_temp <= '0; r_press <= '0; r_depth <= '0;
            case (s_tuser)
              ACT_TEMP: state <= S_T1;
              ACT_PRESS: state <= S_P1;
              ACT_REARM: begin
                armed <= 1'b1;
                state <= S_OUT;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_T1: if (mdone) begin
          temp <= 80'sd2000 + div_pow2(prod, 23);
          state <= S_T6;
        end
        S_T6: if (mdone) begin
          aux <= prod;
          state <= S_T2;
        end
        S_T2: if (mdone) begin
          offw <= (ProductWidth'(c2) <<< 16) + div_pow2(prod, 7);
          state <= S_T3;
        end
        S_T3: if (mdone) begin
          sensw <= (ProductWidth'(c1) <<< 15) + div_pow2(prod, 8);
          state <= S_T4;
        end
        S_T4: if (mdone) begin
          if (temp < 80'sd2000) begin
            temp <= temp - div_pow2(prod * 3, 33);
            offw <= offw - div_pow2(aux * 3, 1);
            sensw <= sensw - div_pow2(aux * 5, 3);
          end else begin
            temp <= temp - div_pow2(prod, 36);
            offw <= offw - div_pow2(aux, 4);
          end
          state <= S_T5;
        end
        S_T5: begin
          off_val <= offw[63:0];
          sens_val <= sensw[63:0];
          r_temp <= sat(temp, TempWidth);
          state <= S_OUT;
        end
        S_P1: if (mdone) begin
          pw <= div_pow2(div_pow2(prod, 21) - ProductWidth'(off_val), 13);
          state <= S_P2;
        end
        S_P2: begin
          if (armed) begin
            base_p <= psat[PressWidth-1:0];
            armed <= 1'b0;
            pdiff <= '0;
          end else begin
            pdiff <= OperandWidth'(psat - ProductWidth'(base_p));
          end
          r_press <= psat;
          state <= S_P3;
        end
        S_P3: if (mdone) begin
          r_depth <= sat(prod >>> 16, DepthWidth);
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign m_tuser = out_kind;
  assign m_tdata = out_data;
endmodule

>>> hw/rtl/psc_mul.sv
// shared signed multiplier, 40x40 in four 20-bit digit steps
module psc_mul (
  input  logic clk,
  input  logic rst,
  input  psc_pkg::mul_req_t req,
  output logic done,
  output logic signed [psc_pkg::ProductWidth-1:0] product
);
  import psc_pkg::*;

  localparam int Digit = OperandWidth / 2;

  logic [OperandWidth-1:0] ua;
  logic [OperandWidth-1:0] ub;
  logic negate;
  logic [1:0] step;
  logic busy;
  logic [ProductWidth-1:0] acc;
  logic [Digit-1:0] da;
  logic [Digit-1:0] db;
  logic [2*Digit-1:0] part;
  logic [ProductWidth-1:0] shifted;

  always_comb begin
    da = step[0] ? ua[OperandWidth-1:Digit] : ua[Digit-1:0];
    db = step[1] ? ub[OperandWidth-1:Digit] : ub[Digit-1:0];
    part = da * db;
    shifted = ProductWidth'(part) << (Digit * (32'(step[0]) + 32'(step[1])));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 2'd1;
        if (step == 2'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      ua <= req.a[OperandWidth-1] ? OperandWidth'(-req.a) : req.a;
      ub <= req.b[OperandWidth-1] ? OperandWidth'(-req.b) : req.b;
      negate <= req.a[OperandWidth-1] ^ req.b[OperandWidth-1];
      acc <= '0;
    end else if (busy) begin
      acc <= acc + shifted;
    end
  end

  assign product = negate ? -$signed(acc) : $signed(acc);
endmodule
